[hw/rtl/aesp_pkg.sv]
`timescale 1ns / 1ps

package aesp_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PATH_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ENTRY_COUNT = 1'b1;
    localparam logic [12:0] MAX_PATH_LENGTH_RESET = 13'd511;
    localparam logic [15:0] MAX_ENTRY_COUNT_RESET = 16'hFFFF;

    // archive format
    localparam logic [31:0] MAGIC_WORD   = 32'h214B504D;
    localparam logic [7:0]  VERSION_BYTE = 8'h01;
    localparam logic [3:0]  HEADER_LAST  = 4'd10;
    localparam logic [7:0]  KIND_FILE    = 8'h00;
    localparam logic [7:0]  KIND_DIR     = 8'h01;

    // header faults, first one wins
    localparam logic [1:0] FAULT_NONE    = 2'd0;
    localparam logic [1:0] FAULT_MAGIC   = 2'd1;
    localparam logic [1:0] FAULT_VERSION = 2'd2;
    localparam logic [1:0] FAULT_COUNT   = 2'd3;

    // byte roles
    localparam logic [3:0] ROLE_HEADER    = 4'd0;
    localparam logic [3:0] ROLE_TYPE      = 4'd1;
    localparam logic [3:0] ROLE_PATH_LEN  = 4'd2;
    localparam logic [3:0] ROLE_DATA_LEN  = 4'd3;
    localparam logic [3:0] ROLE_PATH      = 4'd4;
    localparam logic [3:0] ROLE_FILE_DATA = 4'd5;
    localparam logic [3:0] ROLE_DIR_DATA  = 4'd6;
    localparam logic [3:0] ROLE_TRAILING  = 4'd7;
    localparam logic [3:0] ROLE_IGNORED   = 4'd8;

    // error codes
    localparam logic [3:0] ERR_NONE        = 4'd0;
    localparam logic [3:0] ERR_TOO_SMALL   = 4'd1;
    localparam logic [3:0] ERR_MAGIC       = 4'd2;
    localparam logic [3:0] ERR_VERSION     = 4'd3;
    localparam logic [3:0] ERR_COUNT       = 4'd4;
    localparam logic [3:0] ERR_HEADER_CUT  = 4'd5;
    localparam logic [3:0] ERR_PATH_LENGTH = 4'd6;
    localparam logic [3:0] ERR_DATA_BOUNDS = 4'd7;
    localparam logic [3:0] ERR_TYPE        = 4'd8;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  byte_out;
        logic [3:0]  role;
        logic [15:0] entry_index;
        logic        entry_is_dir;
        logic        entry_end;
        logic [15:0] files_done;
        logic [3:0]  error_code;
        logic        archive_ok;
    } out_item_t;

endpackage

[hw/rtl/archive_entry_stream_parser_unit.sv]
`timescale 1ns / 1ps

// Results are registered. One byte per cycle is taken while s_ready is high;
// the parse state advances in one pass of field/counter logic. A two-entry
// output buffer keeps s_ready up while one result waits. Reset (aresetn low,
// synchronous) empties the buffer, puts the parser at the header and loads
// max_path_length 511, max_entry_count 65535.
module archive_entry_stream_parser_unit
    import aesp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_ENTRY  = 3'd1;
    localparam logic [2:0] PH_PATH   = 3'd2;
    localparam logic [2:0] PH_DATA   = 3'd3;
    localparam logic [2:0] PH_TRAIL  = 3'd4;
    localparam logic [2:0] PH_FAIL   = 3'd5;

    logic [12:0] max_path_length_reg;
    logic [15:0] max_entry_count_reg;

    logic [2:0]  phase_reg,       phase_next;
    logic [3:0]  pos_reg,         pos_next;
    logic [31:0] assembly_reg,    assembly_next;
    logic [1:0]  fault_reg,       fault_next;
    logic [15:0] entries_reg,     entries_next;
    logic [15:0] entry_num_reg,   entry_num_next;
    logic [7:0]  kind_reg,        kind_next;
    logic [15:0] path_rem_reg,    path_rem_next;
    logic [31:0] data_rem_reg,    data_rem_next;
    logic [15:0] files_reg,       files_next;
    logic        failed_reg,      failed_next;

    out_item_t   out_reg,  skid_reg;
    logic        out_valid_reg, skid_valid_reg;
    out_item_t   result;

    logic        push, pop;
    logic [7:0]  b;
    logic        last;
    logic [3:0]  pos;
    logic [31:0] word;
    logic [1:0]  lane;
    logic [7:0]  kind;
    logic [15:0] path_dec;
    logic [31:0] data_dec;
    logic [15:0] entries_dec;
    logic        finish;
    logic [3:0]  role, err;
    logic        isdir;

    assign s_ready = !skid_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;
    assign push    = s_valid && s_ready;
    assign pop     = out_valid_reg && m_ready;

    assign b    = s_data.byte_in;
    assign last = s_data.last_byte;
    assign pos  = pos_reg;

    always_comb begin
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        assembly_next  = assembly_reg;
        fault_next     = fault_reg;
        entries_next   = entries_reg;
        entry_num_next = entry_num_reg;
        kind_next      = kind_reg;
        path_rem_next  = path_rem_reg;
        data_rem_next  = data_rem_reg;
        files_next     = files_reg;
        failed_next    = failed_reg;
        role           = ROLE_IGNORED;
        isdir          = 1'b0;
        err            = ERR_NONE;
        finish         = 1'b0;
        word           = 32'd0;
        lane           = 2'd0;
        kind           = kind_reg;
        path_dec       = path_rem_reg - 16'd1;
        data_dec       = data_rem_reg - 32'd1;
        entries_dec    = entries_reg - 16'd1;

        case (phase_reg)
            PH_HEADER: begin
                role = ROLE_HEADER;
                if (pos <= 4'd3) begin
                    lane = pos[1:0];
                    word = (pos == 4'd0) ? {24'd0, b}
                                         : (assembly_reg | ({24'd0, b} << {lane, 3'b000}));
                    assembly_next = word;
                    if (pos == 4'd3 && word != MAGIC_WORD && fault_reg == FAULT_NONE) begin
                        fault_next = FAULT_MAGIC;
                    end
                end else if (pos == 4'd4) begin
                    if (b != VERSION_BYTE && fault_reg == FAULT_NONE) begin
                        fault_next = FAULT_VERSION;
                    end
                end else if (pos <= 4'd8) begin
                    lane = 2'(pos - 4'd5);
                    word = (pos == 4'd5) ? {24'd0, b}
                                         : (assembly_reg | ({24'd0, b} << {lane, 3'b000}));
                    assembly_next = word;
                    if (pos == 4'd8) begin
                        if (word[31:16] != 16'd0 || word[15:0] > max_entry_count_reg) begin
                            if (fault_reg == FAULT_NONE) begin
                                fault_next = FAULT_COUNT;
                            end
                        end else begin
                            entries_next = word[15:0];
                        end
                    end
                end
                if (pos >= HEADER_LAST) begin
                    if (fault_reg != FAULT_NONE) begin
                        err = {2'b00, fault_reg} + 4'd1;
                    end else if (entries_reg == 16'd0) begin
                        phase_next = PH_TRAIL;
                    end else begin
                        phase_next = PH_ENTRY;
                        pos_next   = 4'd0;
                        if (last) err = ERR_HEADER_CUT;
                    end
                end else begin
                    if (last) err = ERR_TOO_SMALL;
                    pos_next = pos + 4'd1;
                end
            end
            PH_ENTRY: begin
                if (pos == 4'd0) kind = b;
                kind_next = kind;
                isdir = (kind == KIND_DIR);
                if (pos == 4'd0) begin
                    role = ROLE_TYPE;
                end else if (pos <= 4'd2) begin
                    role = ROLE_PATH_LEN;
                    path_rem_next = (pos == 4'd1) ? {8'd0, b} : (path_rem_reg | {b, 8'd0});
                end else begin
                    role = ROLE_DATA_LEN;
                    lane = 2'(pos - 4'd3);
                    data_rem_next = (pos == 4'd3) ? {24'd0, b}
                                  : (data_rem_reg | ({24'd0, b} << {lane, 3'b000}));
                end
                if (pos >= 4'd6) begin
                    if (path_rem_reg == 16'd0 || path_rem_reg > {3'd0, max_path_length_reg}
                            || last) begin
                        err = ERR_PATH_LENGTH;
                    end else begin
                        phase_next = PH_PATH;
                    end
                end else begin
                    if (last) err = ERR_HEADER_CUT;
                    pos_next = pos + 4'd1;
                end
            end
            PH_PATH: begin
                role = ROLE_PATH;
                isdir = (kind_reg == KIND_DIR);
                path_rem_next = path_dec;
                if (path_dec == 16'd0) begin
                    if (kind_reg > KIND_DIR) begin
                        err = ERR_TYPE;
                    end else if (data_rem_reg == 32'd0) begin
                        finish = 1'b1;
                    end else if (last) begin
                        err = ERR_DATA_BOUNDS;
                    end else begin
                        phase_next = PH_DATA;
                    end
                end else if (last) begin
                    err = ERR_PATH_LENGTH;
                end
            end
            PH_DATA: begin
                isdir = (kind_reg == KIND_DIR);
                role = isdir ? ROLE_DIR_DATA : ROLE_FILE_DATA;
                data_rem_next = data_dec;
                if (data_dec == 32'd0) begin
                    finish = 1'b1;
                end else if (last) begin
                    err = ERR_DATA_BOUNDS;
                end
            end
            PH_TRAIL: begin
                role = ROLE_TRAILING;
            end
            default: begin
                role = ROLE_IGNORED;
            end
        endcase

        // close the entry; a final byte here with entries left means a cut header
        if (finish) begin
            if (kind_reg == KIND_FILE) files_next = files_reg + 16'd1;
            entry_num_next = entry_num_reg + 16'd1;
            entries_next   = entries_dec;
            if (entries_dec == 16'd0) begin
                phase_next = PH_TRAIL;
            end else begin
                phase_next = PH_ENTRY;
                pos_next   = 4'd0;
                if (last) err = ERR_HEADER_CUT;
            end
        end

        if (err != ERR_NONE) begin
            failed_next = 1'b1;
            phase_next  = PH_FAIL;
        end

        result.byte_out     = b;
        result.role         = role;
        result.entry_index  = entry_num_reg;
        result.entry_is_dir = isdir;
        result.entry_end    = finish;
        result.files_done   = files_next;
        result.error_code   = err;
        result.archive_ok   = last && !failed_next;

        if (last) begin
            phase_next     = PH_HEADER;
            pos_next       = 4'd0;
            assembly_next  = 32'd0;
            fault_next     = FAULT_NONE;
            entries_next   = 16'd0;
            entry_num_next = 16'd0;
            kind_next      = 8'd0;
            path_rem_next  = 16'd0;
            data_rem_next  = 32'd0;
            files_next     = 16'd0;
            failed_next    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_path_length_reg <= MAX_PATH_LENGTH_RESET;
            max_entry_count_reg <= MAX_ENTRY_COUNT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_MAX_PATH_LENGTH: max_path_length_reg <= cfg_wdata[12:0];
                REG_MAX_ENTRY_COUNT: max_entry_count_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HEADER;
            pos_reg       <= 4'd0;
            assembly_reg  <= 32'd0;
            fault_reg     <= FAULT_NONE;
            entries_reg   <= 16'd0;
            entry_num_reg <= 16'd0;
            kind_reg      <= 8'd0;
            path_rem_reg  <= 16'd0;
            data_rem_reg  <= 32'd0;
            files_reg     <= 16'd0;
            failed_reg    <= 1'b0;
        end else if (push) begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            assembly_reg  <= assembly_next;
            fault_reg     <= fault_next;
            entries_reg   <= entries_next;
            entry_num_reg <= entry_num_next;
            kind_reg      <= kind_next;
            path_rem_reg  <= path_rem_next;
            data_rem_reg  <= data_rem_next;
            files_reg     <= files_next;
            failed_reg    <= failed_next;
        end
    end

    // two-entry output buffer: out_reg drives m_, skid_reg catches a stalled transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                out_reg        <= skid_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_reg       <= result;
                out_valid_reg <= 1'b1;
            end else begin
                skid_reg       <= result;
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule

[hw/rtl/aesp_checker.sv]
`timescale 1ns / 1ps

module aesp_checker
    import aesp_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("buffer not empty after reset");

    a_error_not_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.error_code != ERR_NONE |-> !m_data.archive_ok)
        else $error("success reported with an error");

    a_ignored_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.role == ROLE_IGNORED
            |-> m_data.error_code == ERR_NONE && !m_data.archive_ok && !m_data.entry_end)
        else $error("byte after error carries status");

    a_end_role: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.entry_end
            |-> m_data.role == ROLE_PATH || m_data.role == ROLE_FILE_DATA
                || m_data.role == ROLE_DIR_DATA)
        else $error("entry end on a non-payload byte");

endmodule

bind archive_entry_stream_parser_unit aesp_checker u_aesp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
